// ----- hw/rtl/wis_pkg.sv -----
package wis_pkg;

	// default sizing
	localparam int ENTRIES_DEF     = 81;
	localparam int WEIGHT_BITS_DEF = 16;

	// item field widths
	localparam int IDX_W    = 7;
	localparam int WGT_W    = 16;
	localparam int RND_W    = 23;
	localparam int SUM_W    = 23;
	localparam int STATUS_W = 2;

	// input tdata layout: index, weight, random_value
	localparam int IN_IDX_LO = 0;
	localparam int IN_WGT_LO = IN_IDX_LO + IDX_W;
	localparam int IN_RND_LO = IN_WGT_LO + WGT_W;
	localparam int IN_BITS   = IN_RND_LO + RND_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// output tdata layout: chosen_index, total_weight, status
	localparam int OUT_BITS   = IDX_W + SUM_W + STATUS_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// item kinds (tuser)
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAW  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ZERO_SUM = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RND_HIGH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	// controls for the accumulator
	typedef struct packed {
		logic start;
		logic step;
	} acc_ctl_t;

endpackage

// ----- hw/rtl/wis_cell.sv -----
// One weight register of the ring: loads on a write hit, passes its
// value to the neighbor while the ring rotates.
module wis_cell #(
	parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rotate,
	input  logic [WEIGHT_BITS-1:0] shift_in,
	input  logic                   wr_en,
	input  logic [WEIGHT_BITS-1:0] wr_data,
	output logic [WEIGHT_BITS-1:0] weight
);

	logic [WEIGHT_BITS-1:0] weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else if (rotate) begin
			weight_q <= shift_in;
		end else if (wr_en) begin
			weight_q <= wr_data;
		end
	end

	assign weight = weight_q;

endmodule

// ----- hw/rtl/wis_acc.sv -----
// Saturating running sum over the ring head, records first index whose
// running sum exceeds the random value.
module wis_acc #(
	parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF,
	parameter int CNT_W       = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wis_pkg::acc_ctl_t         ctl,
	input  logic [wis_pkg::RND_W-1:0] rnd,
	input  logic [WEIGHT_BITS-1:0]    head,
	input  logic [CNT_W-1:0]          cnt,
	output logic [wis_pkg::SUM_W-1:0] sum,
	output logic                      found,
	output logic [CNT_W-1:0]          pick
);

	localparam int ADD_W = ((WEIGHT_BITS > wis_pkg::SUM_W) ? WEIGHT_BITS : wis_pkg::SUM_W) + 1;

	logic [wis_pkg::SUM_W-1:0] sum_q;
	logic [wis_pkg::RND_W-1:0] rnd_q;
	logic                      found_q;
	logic [CNT_W-1:0]          pick_q;
	logic [ADD_W-1:0]          add_full;
	logic [wis_pkg::SUM_W-1:0] sum_nxt;

	always_comb begin
		add_full = ADD_W'(sum_q) + ADD_W'(head);
		if (add_full > ADD_W'(wis_pkg::SUM_MAX)) begin
			sum_nxt = wis_pkg::SUM_MAX;
		end else begin
			sum_nxt = add_full[wis_pkg::SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			found_q <= 1'b0;
			pick_q  <= '0;
			rnd_q   <= '0;
		end else if (ctl.start) begin
			sum_q   <= '0;
			found_q <= 1'b0;
			pick_q  <= '0;
			rnd_q   <= rnd;
		end else if (ctl.step) begin
			sum_q <= sum_nxt;
			if (!found_q && (sum_nxt > rnd_q)) begin
				found_q <= 1'b1;
				pick_q  <= cnt;
			end
		end
	end

	assign sum   = sum_q;
	assign found = found_q;
	assign pick  = pick_q;

endmodule

// ----- hw/rtl/weighted_index_sampler.sv -----
// Channel | Dir | Signals                    | Content
// s       | in  | s_tvalid/s_tready/s_tdata  | index, weight, random_value
//         |     | s_tuser                    | op (0 write weight, 1 draw)
// m       | out | m_tvalid/m_tready/m_tdata  | chosen_index, total_weight, status
//
// A write item gives no result; reset clears all weights, no clearing pass.
// A draw runs one ring step per entry through the accumulator, then the finish state
// loads the result register; the next item can be taken once the finish state has
// returned to idle.
// No item is taken during a draw; a finished draw waits in the finish state while
// the previous result is still held on m.
module weighted_index_sampler #(
	parameter int ENTRIES     = wis_pkg::ENTRIES_DEF,
	parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [wis_pkg::IN_DATA_W-1:0]  s_tdata,  // index[6:0], weight[22:7], random_value[45:23]
	input  logic                           s_tuser,  // op[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [wis_pkg::OUT_DATA_W-1:0] m_tdata   // chosen_index[6:0], total_weight[29:7], status[31:30]
);

	localparam int CNT_W = $clog2(ENTRIES);
	localparam int WIDE_W = CNT_W + wis_pkg::IDX_W;

	wis_pkg::state_t state_q;

	logic                           in_acc;
	logic [WIDE_W-1:0]              idx_wide;
	logic                           wr_hit;
	logic [wis_pkg::WGT_W+WEIGHT_BITS-1:0] wgt_ext;
	logic [WEIGHT_BITS-1:0]         wr_data;
	logic [WEIGHT_BITS-1:0]         cell_w [ENTRIES];
	logic                           rotate;
	logic [CNT_W-1:0]               cnt_q;
	logic                           cnt_last;
	wis_pkg::acc_ctl_t              acc_ctl;
	logic [wis_pkg::SUM_W-1:0]      acc_sum;
	logic                           acc_found;
	logic [CNT_W-1:0]               acc_pick;
	logic [WIDE_W-1:0]              pick_wide;
	logic                           out_free;

	logic [wis_pkg::IDX_W-1:0]      chosen_q;
	logic [wis_pkg::SUM_W-1:0]      total_q;
	logic [wis_pkg::STATUS_W-1:0]   status_q;
	logic                           m_valid_q;

	assign s_tready = (state_q == wis_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// writes beyond the store are dropped
	assign idx_wide = {{CNT_W{1'b0}}, s_tdata[wis_pkg::IN_IDX_LO +: wis_pkg::IDX_W]};
	assign wr_hit   = in_acc && (s_tuser == wis_pkg::OP_WRITE)
		&& (idx_wide < WIDE_W'(ENTRIES));
	assign wgt_ext  = {{WEIGHT_BITS{1'b0}}, s_tdata[wis_pkg::IN_WGT_LO +: wis_pkg::WGT_W]};
	assign wr_data  = wgt_ext[WEIGHT_BITS-1:0];

	assign rotate = (state_q == wis_pkg::ST_RUN);

	// weight ring: cell 0 is the head, each cell takes its upper neighbor,
	// so after a full turn of the ring every weight is back in place
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		wis_cell #(
			.WEIGHT_BITS(WEIGHT_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rotate  (rotate),
			.shift_in(cell_w[(i + 1) % ENTRIES]),
			.wr_en   (wr_hit && (idx_wide == WIDE_W'(i))),
			.wr_data (wr_data),
			.weight  (cell_w[i])
		);
	end

	assign acc_ctl.start = in_acc && (s_tuser == wis_pkg::OP_DRAW);
	assign acc_ctl.step  = rotate;

	wis_acc #(
		.WEIGHT_BITS(WEIGHT_BITS),
		.CNT_W      (CNT_W)
	) u_acc (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (acc_ctl),
		.rnd   (s_tdata[wis_pkg::IN_RND_LO +: wis_pkg::RND_W]),
		.head  (cell_w[0]),
		.cnt   (cnt_q),
		.sum   (acc_sum),
		.found (acc_found),
		.pick  (acc_pick)
	);

	assign cnt_last  = (cnt_q == CNT_W'(ENTRIES - 1));
	assign pick_wide = {{wis_pkg::IDX_W{1'b0}}, acc_pick};
	assign out_free  = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wis_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				wis_pkg::ST_IDLE: begin
					if (acc_ctl.start) begin
						cnt_q   <= '0;
						state_q <= wis_pkg::ST_RUN;
					end
				end
				wis_pkg::ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= wis_pkg::ST_FIN;
					end
				end
				wis_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= wis_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= wis_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == wis_pkg::ST_FIN) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == wis_pkg::ST_FIN) && out_free) begin
			total_q <= acc_sum;
			if (acc_sum == '0) begin
				status_q <= wis_pkg::STATUS_ZERO_SUM;
				chosen_q <= '0;
			end else if (!acc_found) begin
				// no running sum passed r, so r is at or above the total
				status_q <= wis_pkg::STATUS_RND_HIGH;
				chosen_q <= '0;
			end else begin
				status_q <= wis_pkg::STATUS_OK;
				chosen_q <= pick_wide[wis_pkg::IDX_W-1:0];
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = wis_pkg::OUT_DATA_W'({status_q, total_q, chosen_q});

endmodule
